// ----- sv/sff_pkg.sv -----
// sff_pkg: shared types and constants for the stereo fir filter
// used by sff_front, sff_back and stereo_fir_filter; no dependencies
`default_nettype none

package sff_pkg;

  // number of taps, a power of two from 2 to 32
  localparam int TAPS   = 32;
  localparam int TAP_W  = $clog2(TAPS);
  // exact accumulator: 32-bit products summed over TAPS terms
  localparam int ACC_W  = 32 + TAP_W;
  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // tuser codes on the input side
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // one queued command
  typedef struct packed {
    logic                    load;
    logic [TAP_W-1:0]        idx;
    logic signed [15:0]      coef;
    logic signed [15:0]      left;
    logic signed [15:0]      right;
    logic                    last;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MAC,
    B_DRAIN,
    B_OUT
  } back_state_t;

endpackage

`default_nettype wire

// ----- sv/sff_front.sv -----
// sff_front: input side, decodes each word into a command and queues it
// depends on sff_pkg
`default_nettype none

module sff_front import sff_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_pop
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   q_count;
  logic              accept;
  logic              keep;
  logic              enq;
  cmd_t              in_cmd;

  assign s_tready = (q_count != (QPTR_W+1)'(QDEPTH));
  assign accept   = s_tvalid && s_tready;

  // loads aimed past the last tap are dropped here
  assign keep = (s_tuser == FUNC_SAMPLE) || (int'(s_tdata[4:0]) < TAPS);
  assign enq  = accept && keep;

  always_comb begin
    in_cmd.load  = (s_tuser == FUNC_LOAD);
    in_cmd.idx   = TAP_W'(s_tdata[4:0]);
    in_cmd.coef  = s_tdata[20:5];
    in_cmd.left  = s_tdata[36:21];
    in_cmd.right = s_tdata[52:37];
    in_cmd.last  = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({enq, cmd_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  assign cmd_valid = (q_count != '0);
  assign cmd       = q_mem[rd_ptr];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QPTR_W+1)'(QDEPTH))
    else $error("command queue overfilled");

endmodule

`default_nettype wire

// ----- sv/sff_back.sv -----
// sff_back: coefficient and history stores, shared mac loop, rounding, output register
// depends on sff_pkg; commands come from sff_front
`default_nettype none

module sff_back import sff_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  output logic             m_tlast
);

  back_state_t             state;
  back_state_t             state_next;
  logic [TAP_W-1:0]        wpos;
  logic [TAP_W-1:0]        cur_pos;
  logic [TAP_W-1:0]        k;
  logic                    last_flag;
  logic                    issue;
  logic                    out_load;
  logic                    start;

  logic [31:0]             hist_mem [TAPS];
  logic [15:0]             coef_mem [TAPS];
  logic [TAPS-1:0]         hist_valid;
  logic [TAPS-1:0]         coef_valid;
  logic [TAP_W-1:0]        h_addr;
  logic [TAP_W-1:0]        c_addr;

  logic [31:0]             rd_hist;
  logic [15:0]             rd_coef;
  logic                    rd_hv;
  logic                    rd_cv;
  logic                    rd_v;
  logic signed [15:0]      op_l;
  logic signed [15:0]      op_r;
  logic signed [15:0]      op_c;
  logic signed [31:0]      prod_l;
  logic signed [31:0]      prod_r;
  logic                    pr_v;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;

  function automatic logic [15:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]    r;
    logic signed [ACC_W-15:0] q;
    logic [15:0]              y;
    r = (ACC_W+1)'(a) + (ACC_W+1)'(16384);
    q = (ACC_W-14)'(r >>> 15);
    if (q > (ACC_W-14)'(32767)) begin
      y = 16'h7fff;
    end else if (q < -(ACC_W-14)'(32768)) begin
      y = 16'h8000;
    end else begin
      y = q[15:0];
    end
    return y;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (cmd_valid && !cmd.load) state_next = B_MAC;
      B_MAC:   if (k == TAP_W'(TAPS-1)) state_next = B_DRAIN;
      B_DRAIN: if (!rd_v && !pr_v) state_next = B_OUT;
      B_OUT:   if (!m_tvalid || m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop  = (state == B_IDLE) && cmd_valid;
    issue    = (state == B_MAC);
    out_load = (state == B_OUT) && (!m_tvalid || m_tready);
  end

  assign start  = cmd_pop && !cmd.load;
  assign h_addr = cur_pos - k;
  assign c_addr = TAP_W'(TAPS-1) - k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      wpos       <= '0;
      hist_valid <= '0;
      coef_valid <= '0;
      rd_v       <= 1'b0;
      pr_v       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      pr_v  <= rd_v;
      if (cmd_pop && cmd.load) begin
        coef_valid[cmd.idx] <= 1'b1;
      end
      if (start) begin
        hist_valid[wpos] <= 1'b1;
        wpos             <= wpos + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // stores, written on pop and read one tap per cycle
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.load) begin
      coef_mem[cmd.idx] <= cmd.coef;
    end
    if (start) begin
      hist_mem[wpos] <= {cmd.right, cmd.left};
    end
    rd_hist <= hist_mem[h_addr];
    rd_coef <= coef_mem[c_addr];
    rd_hv   <= hist_valid[h_addr];
    rd_cv   <= coef_valid[c_addr];
  end

  // never-written entries read as zero
  assign op_l = rd_hv ? signed'(rd_hist[15:0])  : '0;
  assign op_r = rd_hv ? signed'(rd_hist[31:16]) : '0;
  assign op_c = rd_cv ? signed'(rd_coef)        : '0;

  always_ff @(posedge clk) begin
    if (start) begin
      cur_pos   <= wpos;
      k         <= '0;
      last_flag <= cmd.last;
    end else if (issue) begin
      k <= k + 1'b1;
    end
    prod_l <= op_l * op_c;
    prod_r <= op_r * op_c;
    if (start) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (pr_v) begin
      acc_l <= acc_l + ACC_W'(prod_l);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (out_load) begin
      m_tdata <= {round_sat(acc_r), round_sat(acc_l)};
      m_tlast <= last_flag;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == B_IDLE)
    else $error("command popped while a sample is in flight");

  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    pr_v |-> (state == B_MAC || state == B_DRAIN))
    else $error("product accumulated outside the mac loop");

  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result register not presented after load");

endmodule

`default_nettype wire

// ----- sv/stereo_fir_filter.sv -----
// stereo_fir_filter: each popped sample word runs its TAPS tap reads, drains through the
// read, product and accumulate registers, then is rounded and loaded, raising m_tvalid
// the back pops a new sample word only once the one before is loaded, and pops one load word
// per cycle while idle; the input queue (4 words) accepts while not full, also while a result
// waits in the output register; synchronous active-high rst clears control, history and
// coefficients read as zero at once; depends on sff_pkg, sff_front, sff_back
`default_nettype none

module stereo_fir_filter import sff_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // coef_index[4:0], coef_value[20:5], left_in[36:21],
                                      // right_in[52:37], zero[55:53]
  input  wire logic        s_tuser,   // func: 0 = sample, 1 = coefficient load
  input  wire logic        s_tlast,   // block_end
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // left_out[15:0], right_out[31:16]
  output logic             m_tlast    // block_end_out
);

  // command hand-off between the front and the back
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: decodes words, drops out-of-range loads, queues the rest in order
  sff_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: applies loads, runs the shared two-channel mac over all taps,
  // then rounds, saturates and holds the result word
  sff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
